@@ design/sfir_pkg.sv @@
// Package for the stereo Q31 FIR filter: sequencer state type, Q31 limits
// and the output saturation function.
// No dependencies.
package sfir_pkg;

  // Q31 limits of the output
  localparam logic signed [31:0] Q31_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q31_MIN = 32'sh8000_0000;

  // Request kinds carried on req_type
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF   = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RUN   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_SHIFT = 5'b01000,
    ST_OUT   = 5'b10000
  } sfir_state_t;

  // Clamp a shifted 64-bit sum to the Q31 range
  function automatic logic signed [31:0] sat_q31(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = Q31_MAX;
    end else if (v < -64'sd2147483648) begin
      r = Q31_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ design/stereo_fir_q31.sv @@
// Each sample takes one pass of the shared multiply-accumulate per channel over
// the TAPS coefficient/history reads, then a shift and the output register; a
// stalled output holds the result back. The input stalls until it is registered.
// A coefficient write never stalls; the next transfer is taken at once.
// Reset (rst, synchronous): sequencer idle, write position and warm-up count
// cleared, fraction_shift = 31; the history needs no clearing pass.
module stereo_fir_q31
  import sfir_pkg::*;
#(
  parameter int TAPS = 256
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_wen,
  input  logic [5:0]         cfg_wdata,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic signed [31:0] left_in,
  input  logic signed [31:0] right_in,
  input  logic [7:0]         coef_index,
  input  logic signed [31:0] coef_value,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] left_out,
  output logic signed [31:0] right_out
);

  localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int WW = $clog2(TAPS + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TAPS - 1);
  localparam logic [WW-1:0] WARM_DONE = WW'(TAPS);

  sfir_state_t state;

  logic [5:0]         fraction_shift;
  logic [AW-1:0]      wp;
  logic [WW-1:0]      warm;
  logic               mute;

  // read address counters
  logic [AW-1:0]      h_addr;
  logic [AW-1:0]      c_addr;

  // memories
  logic signed [31:0] lh_mem [TAPS];
  logic signed [31:0] rh_mem [TAPS];
  logic signed [31:0] cf_mem [TAPS];

  // pipeline: read data -> product -> accumulate
  logic               rd_v, rd_last;
  logic signed [31:0] l_rd, r_rd, c_rd;
  logic               pv, plast;
  logic signed [63:0] l_prod, r_prod;
  logic signed [63:0] l_acc, r_acc;
  logic signed [63:0] l_shift, r_shift;

  logic               in_xfer, smp_xfer, coef_xfer, coef_ok;
  logic               out_free;

  assign in_stall  = (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign smp_xfer  = in_xfer && (req_type == REQ_SAMPLE);
  assign coef_xfer = in_xfer && (req_type == REQ_COEF);
  assign coef_ok   = (32'(coef_index) < 32'(TAPS));
  assign out_free  = !out_valid || !out_stall;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      fraction_shift <= 6'd31;
    end else if (cfg_wen) begin
      fraction_shift <= cfg_wdata;
    end
  end

  // history memories: sample write at transfer, one read per cycle
  always_ff @(posedge clk) begin
    if (smp_xfer) begin
      lh_mem[wp] <= left_in;
      rh_mem[wp] <= right_in;
    end
    l_rd <= lh_mem[h_addr];
    r_rd <= rh_mem[h_addr];
  end

  // coefficient memory
  always_ff @(posedge clk) begin
    if (coef_xfer && coef_ok) begin
      cf_mem[AW'(coef_index)] <= coef_value;
    end
    c_rd <= cf_mem[c_addr];
  end

  // sequencer and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wp        <= '0;
      warm      <= '0;
      rd_v      <= 1'b0;
      pv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_v <= (state == ST_RUN);
      pv   <= rd_v;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (smp_xfer) begin
            wp    <= (wp == LAST_ADDR) ? '0 : wp + 1'b1;
            if (warm != WARM_DONE) begin
              warm <= warm + 1'b1;
            end
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (c_addr == LAST_ADDR) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (pv && plast) begin
            state <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath: addresses, products, accumulators, shift, output register
  always_ff @(posedge clk) begin
    if (smp_xfer) begin
      h_addr <= wp;
      c_addr <= '0;
      mute   <= (warm != WARM_DONE);
      l_acc  <= '0;
      r_acc  <= '0;
    end else begin
      if (state == ST_RUN) begin
        h_addr <= (h_addr == '0) ? LAST_ADDR : h_addr - 1'b1;
        c_addr <= c_addr + 1'b1;
      end
      if (pv) begin
        l_acc <= l_acc + l_prod;
        r_acc <= r_acc + r_prod;
      end
    end
    rd_last <= (c_addr == LAST_ADDR);
    plast   <= rd_last;
    l_prod  <= l_rd * c_rd;
    r_prod  <= r_rd * c_rd;
    if (state == ST_SHIFT) begin
      l_shift <= l_acc >>> fraction_shift;
      r_shift <= r_acc >>> fraction_shift;
    end
    if ((state == ST_OUT) && out_free) begin
      left_out  <= mute ? '0 : sat_q31(l_shift);
      right_out <= mute ? '0 : sat_q31(r_shift);
    end
  end

endmodule

@@ design/sfir_checker.sv @@
// Port-level checks for the stereo Q31 FIR filter, bound to the top level.
// Depends on stereo_fir_q31 only through the bind below.
module sfir_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               req_type,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] left_out,
  input logic signed [31:0] right_out
);

  // reset leaves the block empty and ready
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  // a sample transfer starts the filter pass
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !req_type) |=> in_stall)
    else $error("sample transfer did not start a pass");

  // a coefficient write does not stall the input
  a_coef: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && req_type) |=> !in_stall)
    else $error("coefficient write stalled the input");

  // a new result only appears at the end of a pass
  a_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a filter pass");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(left_out) && $stable(right_out))
    else $error("stalled result changed");

endmodule

bind stereo_fir_q31 sfir_checker u_sfir_checker (.*);

@@ sim/tb.sv @@
// Self-checking testbench for stereo_fir_q31: coefficient loads, warm-up,
// Q31 filtering, shift settings and saturation under random flow control.
// Depends on sfir_pkg and the stereo_fir_q31 RTL.
module tb
  import sfir_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPS         = 256;
  localparam int CLK_PERIOD   = 10;
  localparam int QUIET_LIMIT  = 20 * TAPS + 1000;
  localparam int MAX_REPORTS  = 100;

  typedef struct packed {
    logic signed [31:0] left;
    logic signed [31:0] right;
  } stereo_pair_t;

  // Filter predictor plus queue of the output pairs still owed by the block
  class fir_scoreboard;
    logic signed [31:0] left_hist  [TAPS];
    logic signed [31:0] right_hist [TAPS];
    logic signed [31:0] coef       [TAPS];
    int unsigned        wr_pos;
    int unsigned        warm_cnt;
    logic [5:0]         frac_shift;
    stereo_pair_t       expected_pairs[$];
    int unsigned        errors;

    function new();
      foreach (coef[i]) begin
        left_hist[i]  = '0;
        right_hist[i] = '0;
        coef[i]       = '0;
      end
      wr_pos     = 0;
      warm_cnt   = 0;
      frac_shift = 6'd31;
      errors     = 0;
    endfunction

    function void set_shift(logic [5:0] v);
      frac_shift = v;
    endfunction

    function int pending();
      return expected_pairs.size();
    endfunction

    // In range when the upper 33 bits are all copies of the sign
    function logic signed [31:0] clamp_q31(logic signed [63:0] v);
      if (v[63:31] == {33{v[63]}}) return v[31:0];
      return v[63] ? Q31_MIN : Q31_MAX;
    endfunction

    // Accepted input transfer: coefficient load, or a sample that owes one pair
    function void note_transfer(logic kind, logic signed [31:0] l, logic signed [31:0] r,
                                logic [7:0] idx, logic signed [31:0] val);
      logic signed [63:0] acc_l, acc_r, prod_l, prod_r;
      stereo_pair_t       pair;
      int unsigned        pos;
      int                 i;
      if (kind == REQ_COEF) begin
        if (idx < TAPS) coef[idx] = val;
        return;
      end
      left_hist[wr_pos]  = l;
      right_hist[wr_pos] = r;
      acc_l = '0;
      acc_r = '0;
      // newest sample meets tap 0; sums wrap at 64 bits
      for (i = 0; i < TAPS; i++) begin
        pos    = (wr_pos + TAPS - i) % TAPS;
        prod_l = left_hist[pos] * coef[i];
        prod_r = right_hist[pos] * coef[i];
        acc_l  = acc_l + prod_l;
        acc_r  = acc_r + prod_r;
      end
      pair.left  = clamp_q31(acc_l >>> frac_shift);
      pair.right = clamp_q31(acc_r >>> frac_shift);
      // muted until the history has been filled once
      if (warm_cnt < TAPS) begin
        warm_cnt++;
        pair = '0;
      end
      wr_pos = (wr_pos + 1) % TAPS;
      expected_pairs.push_back(pair);
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task check_output(logic signed [31:0] l, logic signed [31:0] r);
      stereo_pair_t want;
      if (expected_pairs.size() == 0) begin
        report_mismatch($sformatf("output pair %h/%h with nothing pending", l, r));
        return;
      end
      want = expected_pairs.pop_front();
      if (l !== want.left)
        report_mismatch($sformatf("left_out %h, expected %h", l, want.left));
      if (r !== want.right)
        report_mismatch($sformatf("right_out %h, expected %h", r, want.right));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_wen;
  logic [5:0]         cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic               req_type;
  logic signed [31:0] left_in;
  logic signed [31:0] right_in;
  logic [7:0]         coef_index;
  logic signed [31:0] coef_value;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] left_out;
  logic signed [31:0] right_out;

  fir_scoreboard fir_sb;
  int            send_idle_pct;
  int            stall_pct;
  int            quiet_cycles;

  stereo_fir_q31 #(
    .TAPS(TAPS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .left_in    (left_in),
    .right_in   (right_in),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .left_out   (left_out),
    .right_out  (right_out)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  // Output monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) fir_sb.check_output(left_out, right_out);
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Mostly full-scale samples, with rails and near-zero values mixed in
  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 19))
      0:       return Q31_MAX;
      1:       return Q31_MIN;
      2, 3:    return 32'(int'($urandom_range(0, 4095)) - 2048);
      default: return $urandom();
    endcase
  endfunction

  // Mostly small taps so that shift 31 gives unsaturated outputs too
  function automatic logic [31:0] rand_coef();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) return 32'(int'($urandom_range(0, 131071)) - 65536);
    if (pick < 95) return 32'(int'($urandom_range(0, 134217727)) - 67108864);
    if (pick == 95) return Q31_MAX;
    if (pick == 96) return Q31_MIN;
    return $urandom();
  endfunction

  // One input transfer, preceded by a random idle gap
  task automatic send_transfer(input logic kind, input logic [31:0] l, input logic [31:0] r,
                               input logic [7:0] idx, input logic [31:0] val);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    left_in    <= l;
    right_in   <= r;
    coef_index <= idx;
    coef_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fir_sb.note_transfer(kind, l, r, idx, val);
  endtask

  // Hold off the sender until every owed pair has come out
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (fir_sb.pending() != 0);
  endtask

  // Drain, let a trailing coefficient load settle, then set the shift
  task automatic start_phase(input int send_pct, input int stall_pct_v,
                             input logic [5:0] shift_v);
    wait_for_results();
    repeat (TAPS + 10) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= shift_v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    fir_sb.set_shift(shift_v);
    send_idle_pct = send_pct;
    stall_pct     = stall_pct_v;
  endtask

  task automatic run_random(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 149) == 0) wait_for_results();
      if ($urandom_range(0, 4) == 0) begin
        send_transfer(REQ_COEF, $urandom(), $urandom(), 8'($urandom_range(0, 255)),
                      rand_coef());
      end else begin
        send_transfer(REQ_SAMPLE, rand_sample(), rand_sample(), 8'($urandom()), $urandom());
      end
    end
  endtask

  initial begin
    int k;
    fir_sb        = new();
    send_idle_pct = 0;
    stall_pct     = 0;
    rst        <= 1'b1;
    cfg_wen    <= 1'b0;
    cfg_wdata  <= '0;
    in_valid   <= 1'b0;
    req_type   <= REQ_SAMPLE;
    left_in    <= '0;
    right_in   <= '0;
    coef_index <= '0;
    coef_value <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Full rate, reset shift: load every tap, then run through warm-up
    start_phase(0, 0, 6'd31);
    for (k = 0; k < TAPS; k++) begin
      send_transfer(REQ_COEF, $urandom(), $urandom(), 8'(k), rand_coef());
    end
    for (k = 0; k < TAPS; k++) begin
      send_transfer(REQ_SAMPLE, rand_sample(), rand_sample(), 8'($urandom()), $urandom());
    end

    // Rail taps at both ends of the line, then rail and sign-edge samples
    send_transfer(REQ_COEF, '0, '0, 8'd0, Q31_MAX);
    send_transfer(REQ_COEF, '1, '1, 8'd255, Q31_MIN);
    send_transfer(REQ_SAMPLE, Q31_MAX, Q31_MIN, 8'h00, 32'h0);
    send_transfer(REQ_SAMPLE, Q31_MIN, Q31_MAX, 8'hFF, 32'hFFFF_FFFF);
    send_transfer(REQ_SAMPLE, 32'sd0, 32'sd0, 8'h00, 32'h0);
    send_transfer(REQ_SAMPLE, -32'sd1, 32'sd1, 8'hFF, 32'hFFFF_FFFF);
    send_transfer(REQ_SAMPLE, Q31_MAX, Q31_MAX, 8'h00, 32'h0);
    send_transfer(REQ_SAMPLE, Q31_MIN, Q31_MIN, 8'hFF, 32'hFFFF_FFFF);
    send_transfer(REQ_SAMPLE, 32'sd1, -32'sd1, 8'h00, 32'h0);
    wait_for_results();
    send_transfer(REQ_COEF, '0, '0, 8'd0, 32'sd0);
    send_transfer(REQ_SAMPLE, Q31_MAX, Q31_MIN, 8'h00, 32'h0);
    send_transfer(REQ_COEF, '0, '0, 8'd0, rand_coef());
    send_transfer(REQ_COEF, '0, '0, 8'd255, rand_coef());
    run_random(180);

    // Shift extremes and the remaining flow-control mixes
    start_phase(81, 0, 6'd0);
    run_random(180);
    start_phase(0, 81, 6'd63);
    run_random(180);
    start_phase(34, 34, 6'($urandom_range(1, 62)));
    run_random(180);
    start_phase(0, 0, 6'd15);
    run_random(90);
    wait_for_results();
    run_random(90);

    // Drain and allow for any late, unexpected output
    wait_for_results();
    repeat (TAPS + 20) @(posedge clk);
    if (fir_sb.pending() != 0)
      fir_sb.report_mismatch($sformatf("%0d output pairs never came", fir_sb.pending()));
    if (fir_sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
